### design/increasing_subsequence_counter_core_macros.svh
// Assertion macros shared by the increasing subsequence counter RTL.
// Depends on nothing; the modules that use them must declare i_clk and i_rst_n.
`ifndef INCREASING_SUBSEQUENCE_COUNTER_CORE_MACROS_SVH
`define INCREASING_SUBSEQUENCE_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ISC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/isc_pkg.sv
// Package for the increasing subsequence counter: sizes, payload structs, codes.
// Depends on nothing; used by every module of the block but isc_ram.
package isc_pkg;

    localparam int MAX_ELEMENTS = 256;
    localparam int MAX_LENGTH   = 16;

    localparam int VAL_W  = 32;
    localparam int CNT_W  = 63;
    localparam int K_W    = 5;
    localparam int IDX_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int LVL_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int ROW_W  = MAX_LENGTH * CNT_W;

    localparam logic [CNT_W-1:0] SAT_MAX = {CNT_W{1'b1}};

    // Item queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_SUBSEQ_LENGTH = '0;
    localparam logic [K_W-1:0]     SUBSEQ_LENGTH_RST = 5'd1;

    typedef struct packed {
        logic signed [VAL_W-1:0] elem_value;
        logic                    is_last;
    } t_in;

    typedef struct packed {
        logic [CNT_W-1:0] subseq_count;
        logic             count_saturated;
        logic             input_overflow;
    } t_out;

    // Classified item as it travels through the queue
    typedef struct packed {
        logic [VAL_W-1:0] key;      // sign-flipped value: unsigned order = signed order
        logic             last;
        logic             k_zero;   // k is zero: result is 1
        logic             k_track;  // 1 <= k <= MAX_LENGTH
        logic [LVL_W-1:0] lvl;      // k - 1 when tracked
    } t_item;

endpackage

### design/isc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module isc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/isc_front.sv
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on isc_pkg and increasing_subsequence_counter_core_macros.svh.
`include "increasing_subsequence_counter_core_macros.svh"

module isc_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  isc_pkg::t_in            i_in,
    input  logic [isc_pkg::K_W-1:0] i_k,
    output logic                    o_busy,
    output logic                    o_head_vld,
    output isc_pkg::t_item          o_head,
    input  logic                    i_pop
);

    isc_pkg::t_item              r_q [isc_pkg::QDEPTH];
    logic [isc_pkg::QPTR_W-1:0]  r_wp, n_wp;
    logic [isc_pkg::QPTR_W-1:0]  r_rp, n_rp;
    logic [isc_pkg::QCNT_W-1:0]  r_cnt, n_cnt;
    logic                        push;
    isc_pkg::t_item              item;

    // Classify: order key and the k decode, sampled with the item
    always_comb begin
        item.key     = {~i_in.elem_value[isc_pkg::VAL_W-1],
                        i_in.elem_value[isc_pkg::VAL_W-2:0]};
        item.last    = i_in.is_last;
        item.k_zero  = (i_k == '0);
        item.k_track = (i_k != '0) && (32'(i_k) <= 32'(isc_pkg::MAX_LENGTH));
        item.lvl     = isc_pkg::LVL_W'(i_k - isc_pkg::K_W'(1));
    end

    assign o_busy     = (r_cnt == isc_pkg::QCNT_W'(isc_pkg::QDEPTH));
    assign push       = i_start && !o_busy;
    assign o_head_vld = (r_cnt != '0);
    assign o_head     = r_q[r_rp];

    always_comb begin
        n_wp  = push  ? r_wp + isc_pkg::QPTR_W'(1) : r_wp;
        n_rp  = i_pop ? r_rp + isc_pkg::QPTR_W'(1) : r_rp;
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + isc_pkg::QCNT_W'(1);
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - isc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    `ISC_ASSERT_NOW(a_pop_nonempty, i_pop, r_cnt != '0, "pop from empty item queue")
    `ISC_ASSERT_NEXT(a_push_grows, push && !i_pop, r_cnt == $past(r_cnt) + 2'd1,
        "queue count did not advance on push")

endmodule

### design/isc_back.sv
// Back end: scans stored rows, builds the new row of counts, keeps the total.
// Depends on isc_pkg, isc_ram and increasing_subsequence_counter_core_macros.svh.
`include "increasing_subsequence_counter_core_macros.svh"

module isc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_vld,
    input  isc_pkg::t_item i_head,
    output logic           o_pop,
    output logic           o_done,
    output isc_pkg::t_out  o_result
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_STORE = 2'd2;

    localparam int ML = isc_pkg::MAX_LENGTH;
    localparam int CW = isc_pkg::CNT_W;

    logic [1:0]                   r_state, n_state;
    isc_pkg::t_item               r_item;
    logic [isc_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [isc_pkg::IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic                         r_rd_vld, n_rd_vld;
    logic [CW-1:0]                r_acc [1:ML-1];
    logic [CW-1:0]                n_acc [1:ML-1];
    logic [CW-1:0]                r_total, n_total;
    logic                         r_sat, n_sat;
    logic                         r_ovf, n_ovf;
    logic                         r_done, n_done;
    isc_pkg::t_out                r_result, n_result;

    logic                         issue;
    logic                         has_room;
    logic                         wr_en;
    logic [isc_pkg::VAL_W-1:0]    rd_val;
    logic [isc_pkg::ROW_W-1:0]    rd_row;
    logic [isc_pkg::ROW_W-1:0]    new_row;
    logic [CW-1:0]                sel_cnt;
    logic [CW:0]                  tot_sum;

    // Skip the scan for a beat that finds the store full: it is dropped uncounted
    assign issue    = (r_state == ST_SCAN) && has_room && (r_rd_idx < r_idx);
    assign has_room = (r_idx < isc_pkg::IDX_W'(isc_pkg::MAX_ELEMENTS));
    assign wr_en    = (r_state == ST_STORE) && has_room;
    assign o_pop    = (r_state == ST_IDLE) && i_head_vld;

    isc_ram #(
        .WIDTH (isc_pkg::VAL_W),
        .DEPTH (isc_pkg::MAX_ELEMENTS)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_idx[isc_pkg::ADDR_W-1:0]),
        .i_wdata (r_item.key),
        .i_raddr (r_rd_idx[isc_pkg::ADDR_W-1:0]),
        .o_rdata (rd_val)
    );

    isc_ram #(
        .WIDTH (isc_pkg::ROW_W),
        .DEPTH (isc_pkg::MAX_ELEMENTS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_idx[isc_pkg::ADDR_W-1:0]),
        .i_wdata (new_row),
        .i_raddr (r_rd_idx[isc_pkg::ADDR_W-1:0]),
        .o_rdata (rd_row)
    );

    // New row: length 1 counts one, longer lengths come from the accumulators
    always_comb begin
        new_row[CW-1:0] = CW'(1);
        for (int l = 1; l < ML; l++) begin
            new_row[l*CW +: CW] = r_acc[l];
        end
        sel_cnt = new_row[r_item.lvl*CW +: CW];
        tot_sum = {1'b0, r_total} + {1'b0, sel_cnt};
    end

    always_comb begin
        logic [CW:0] sum;
        sum      = '0;
        n_state  = r_state;
        n_idx    = r_idx;
        n_rd_idx = r_rd_idx;
        n_rd_vld = 1'b0;
        n_acc    = r_acc;
        n_total  = r_total;
        n_sat    = r_sat;
        n_ovf    = r_ovf;
        n_done   = 1'b0;
        n_result = r_result;
        case (r_state)
            ST_IDLE: begin
                if (i_head_vld) begin
                    n_rd_idx = '0;
                    for (int l = 1; l < ML; l++) begin
                        n_acc[l] = '0;
                    end
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_rd_idx = r_rd_idx + isc_pkg::IDX_W'(1);
                end
                n_rd_vld = issue;
                // Add the earlier row's counts one length down when its value is smaller
                if (r_rd_vld && (rd_val < r_item.key)) begin
                    for (int l = 1; l < ML; l++) begin
                        sum = {1'b0, r_acc[l]} + {1'b0, rd_row[(l-1)*CW +: CW]};
                        if (sum[CW]) begin
                            n_acc[l] = isc_pkg::SAT_MAX;
                            n_sat    = 1'b1;
                        end else begin
                            n_acc[l] = sum[CW-1:0];
                        end
                    end
                end
                if (!issue && !r_rd_vld) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                if (has_room) begin
                    n_idx = r_idx + isc_pkg::IDX_W'(1);
                    if (r_item.k_track) begin
                        if (tot_sum[CW]) begin
                            n_total = isc_pkg::SAT_MAX;
                            n_sat   = 1'b1;
                        end else begin
                            n_total = tot_sum[CW-1:0];
                        end
                    end
                end else begin
                    n_ovf = 1'b1;
                end
                if (r_item.last) begin
                    if (r_item.k_zero) begin
                        n_result.subseq_count = CW'(1);
                    end else if (r_item.k_track) begin
                        n_result.subseq_count = n_total;
                    end else begin
                        n_result.subseq_count = '0;
                    end
                    n_result.count_saturated = n_sat;
                    n_result.input_overflow  = n_ovf;
                    n_done  = 1'b1;
                    n_idx   = '0;
                    n_total = '0;
                    n_sat   = 1'b0;
                    n_ovf   = 1'b0;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
            r_total  <= '0;
            r_sat    <= 1'b0;
            r_ovf    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_rd_idx <= n_rd_idx;
            r_rd_vld <= n_rd_vld;
            r_total  <= n_total;
            r_sat    <= n_sat;
            r_ovf    <= n_ovf;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_head;
        end
        r_acc    <= n_acc;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `ISC_ASSERT_NOW(a_done_after_store, r_done, $past(r_state) == ST_STORE,
        "result strobe without a store cycle")
    `ISC_ASSERT_NOW(a_clear_after_result, r_done, r_idx == '0 && !r_sat && !r_ovf,
        "sequence state not cleared after result")
    `ISC_ASSERT_NOW(a_read_in_range, r_rd_vld, $past(r_rd_idx) < r_idx,
        "scan read beyond stored rows")

endmodule

### design/increasing_subsequence_counter_core.sv
// Flow: an accepted beat waits in the two-entry front queue until the idle back pops it;
// the back scans the n stored rows (none for the first beat of a sequence or for a beat
// dropped past capacity), stores the new row and, on the last beat, registers o_done.
// The scan reads one stored row a cycle; the queue takes two more beats (busy when full).
// Results show for one cycle on o_done; the receiver cannot stall.
// Reset (i_rst_n, synchronous, active low) clears the sequence state; k returns to 1.
module increasing_subsequence_counter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Item channel
    input  logic                        start,
    output logic                        busy,
    input  isc_pkg::t_in                i_in,
    // Result channel
    output logic                        o_done,
    output isc_pkg::t_out               o_result,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [isc_pkg::PADDR_W-1:0] paddr,
    input  logic [isc_pkg::PDATA_W-1:0] pwdata,
    output logic [isc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    logic [isc_pkg::K_W-1:0] r_k;
    logic                    cfg_wr;
    logic                    reg_hit;
    logic                    head_vld;
    isc_pkg::t_item          head;
    logic                    pop;

    // Configuration: the only register is k, at word offset zero
    assign pready  = 1'b1;
    assign reg_hit = (paddr[isc_pkg::PADDR_W-1:2] == isc_pkg::REG_SUBSEQ_LENGTH);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? isc_pkg::PDATA_W'(r_k) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= isc_pkg::SUBSEQ_LENGTH_RST;
        end else if (cfg_wr) begin
            r_k <= pwdata[isc_pkg::K_W-1:0];
        end
    end

    // Front: accept a beat, decode k against it, and queue it
    isc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_in       (i_in),
        .i_k        (r_k),
        .o_busy     (busy),
        .o_head_vld (head_vld),
        .o_head     (head),
        .i_pop      (pop)
    );

    // Back: scan earlier rows, store the new row, advance the total, emit on last
    isc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head_vld (head_vld),
        .i_head     (head),
        .o_pop      (pop),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule
